// File: src/stled_pkg.sv
`timescale 1ns / 1ps
package stled_pkg;

	// fixed field widths
	localparam int SAMPLE_BITS    = 16;
	localparam int SQ_W           = 2 * SAMPLE_BITS;
	localparam int SUM_W          = 41;
	localparam int WIN_W          = 11;
	localparam int THR_W          = 16;
	localparam int IDX_W          = 32;
	localparam int POW_W          = 31;
	localparam int RATIO_W        = 16;
	localparam int CFG_W          = 32;
	localparam int CFG_IDX_W      = 2;
	localparam int DEF_MAX_WINDOW = 1024;

	// register reset values
	localparam logic [WIN_W-1:0] RST_SHORT_WIN = 11'd8;
	localparam logic [WIN_W-1:0] RST_LONG_WIN  = 11'd64;
	localparam logic [THR_W-1:0] RST_THRESHOLD = 16'd768;
	localparam logic [IDX_W-1:0] RST_START     = 32'd0;

	localparam logic [RATIO_W-1:0] RATIO_MAX = {RATIO_W{1'b1}};

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SHORT_WIN   = 2'd0,
		REG_LONG_WIN    = 2'd1,
		REG_THRESHOLD   = 2'd2,
		REG_START_INDEX = 2'd3
	} cfg_reg_t;

	// window sums, lengths and sample index handed from front to back
	typedef struct packed {
		logic [SUM_W-1:0] short_sum;
		logic [SUM_W-1:0] long_sum;
		logic [WIN_W-1:0] short_len;
		logic [WIN_W-1:0] long_len;
		logic [IDX_W-1:0] index;
	} job_t;

	// square of a sample
	function automatic logic [SQ_W-1:0] square(input logic signed [SAMPLE_BITS-1:0] s);
		logic signed [SQ_W-1:0] p;
		p = s * s;
		return p;
	endfunction

endpackage

// File: src/stled_queue.sv
`timescale 1ns / 1ps
module stled_queue import stled_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t wdata,
	output logic full,
	input  logic pop,
	output job_t rdata,
	output logic empty
);

	job_t        mem_q [2];
	logic        wr_q;
	logic        rd_q;
	logic [1:0]  cnt_q;
	logic        do_push;
	logic        do_pop;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_q <= !wr_q;
			end
			if (do_pop) begin
				rd_q <= !rd_q;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

// File: src/stled_front.sv
`timescale 1ns / 1ps
module stled_front import stled_pkg::*; #(
	parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic        [WIN_W-1:0]       short_window,
	input  logic        [WIN_W-1:0]       long_window,
	input  logic        [IDX_W-1:0]       start_index,
	input  logic                          win_changed,
	output logic                          job_push,
	output job_t                          job,
	input  logic                          job_full
);

	localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_OLDS, ST_OLDL, ST_SUB, ST_WR, ST_REC, ST_DRAIN, ST_PUSH
	} state_t;

	state_t                  state_q;
	logic [AW-1:0]           clr_q;
	logic [AW-1:0]           wp_q;
	logic [IDX_W-1:0]        cnt_q;
	logic                    dirty_q;
	logic [SAMPLE_BITS-1:0]  samp_q;
	logic [SQ_W-1:0]         sqn_q;
	logic [SQ_W-1:0]         sqo_q;
	logic [SUM_W-1:0]        ssum_q;
	logic [SUM_W-1:0]        lsum_q;
	logic [WIN_W-1:0]        sw_q;
	logic [WIN_W-1:0]        lw_q;
	logic [IDX_W-1:0]        idx_q;
	logic                    emit_q;
	logic [WIN_W-1:0]        k_q;
	logic [WIN_W-1:0]        kd_q;
	logic                    rv_q;

	logic [SAMPLE_BITS-1:0]  ring_q [MAX_WINDOW];
	logic [SAMPLE_BITS-1:0]  rdata_q;
	logic [AW-1:0]           raddr;
	logic [AW-1:0]           waddr;
	logic [SAMPLE_BITS-1:0]  wdata;
	logic                    we;
	logic [WIN_W-1:0]        kmax;
	logic [SQ_W-1:0]         sq_rd;
	logic [AW-1:0]           wp_next;

	// window length limited to 1 .. MAX_WINDOW
	function automatic logic [WIN_W-1:0] clamp(input logic [WIN_W-1:0] w);
		if (w == '0) begin
			return WIN_W'(1);
		end else if (32'(w) > 32'(MAX_WINDOW)) begin
			return WIN_W'(MAX_WINDOW);
		end
		return w;
	endfunction

	// ring position k places back from the write pointer
	function automatic logic [AW-1:0] back_pos(input logic [AW-1:0] wp,
			input logic [WIN_W-1:0] k);
		logic [31:0] t;
		t = 32'(wp) + 32'(MAX_WINDOW) - 32'(k);
		if (t >= 32'(MAX_WINDOW)) begin
			t = t - 32'(MAX_WINDOW);
		end
		return t[AW-1:0];
	endfunction

	assign full    = (state_q != ST_IDLE);
	assign kmax    = (sw_q > lw_q) ? sw_q : lw_q;
	assign sq_rd   = square(rdata_q);
	assign wp_next = (wp_q == AW'(MAX_WINDOW - 1)) ? '0 : wp_q + AW'(1);

	assign job_push       = (state_q == ST_PUSH) && emit_q && !job_full;
	assign job.short_sum  = ssum_q;
	assign job.long_sum   = lsum_q;
	assign job.short_len  = sw_q;
	assign job.long_len   = lw_q;
	assign job.index      = idx_q;

	// ring port selection
	always_comb begin
		raddr = wp_q;
		we    = 1'b0;
		waddr = wp_q;
		wdata = samp_q;
		unique case (state_q)
			ST_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = '0;
			end
			ST_OLDS: raddr = back_pos(wp_q, sw_q);
			ST_OLDL: raddr = back_pos(wp_q, lw_q);
			ST_SUB,
			ST_WR:   we    = 1'b1;
			ST_REC:  raddr = back_pos(wp_q, k_q);
			default: ;
		endcase
	end

	// sample ring
	always_ff @(posedge clk) begin
		if (we) begin
			ring_q[waddr] <= wdata;
		end
		rdata_q <= ring_q[raddr];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			wp_q    <= '0;
			cnt_q   <= '0;
			dirty_q <= 1'b0;
			samp_q  <= '0;
			sqn_q   <= '0;
			sqo_q   <= '0;
			ssum_q  <= '0;
			lsum_q  <= '0;
			sw_q    <= WIN_W'(1);
			lw_q    <= WIN_W'(1);
			idx_q   <= '0;
			emit_q  <= 1'b0;
			k_q     <= '0;
			kd_q    <= '0;
			rv_q    <= 1'b0;
		end else begin
			if (win_changed) begin
				dirty_q <= 1'b1;
			end
			// accumulate squares during a full recompute
			if ((state_q == ST_REC || state_q == ST_DRAIN) && rv_q) begin
				if (kd_q < sw_q) begin
					ssum_q <= ssum_q + SUM_W'(sq_rd);
				end
				if (kd_q < lw_q) begin
					lsum_q <= lsum_q + SUM_W'(sq_rd);
				end
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(MAX_WINDOW - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (push) begin
						samp_q <= sample;
						sqn_q  <= square(sample);
						sw_q   <= clamp(short_window);
						lw_q   <= clamp(long_window);
						idx_q  <= cnt_q;
						emit_q <= (cnt_q >= start_index);
						if (cnt_q != '1) begin
							cnt_q <= cnt_q + IDX_W'(1);
						end
						state_q <= dirty_q ? ST_WR : ST_OLDS;
					end
				end
				ST_OLDS: state_q <= ST_OLDL;
				ST_OLDL: begin
					sqo_q   <= sq_rd;
					state_q <= ST_SUB;
				end
				ST_SUB: begin
					ssum_q  <= ssum_q + SUM_W'(sqn_q) - SUM_W'(sqo_q);
					lsum_q  <= lsum_q + SUM_W'(sqn_q) - SUM_W'(sq_rd);
					state_q <= ST_PUSH;
				end
				ST_WR: begin
					dirty_q <= 1'b0;
					ssum_q  <= '0;
					lsum_q  <= '0;
					k_q     <= '0;
					rv_q    <= 1'b0;
					state_q <= ST_REC;
				end
				ST_REC: begin
					rv_q <= 1'b1;
					kd_q <= k_q;
					k_q  <= k_q + WIN_W'(1);
					if (k_q == kmax - WIN_W'(1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					rv_q    <= 1'b0;
					state_q <= ST_PUSH;
				end
				ST_PUSH: begin
					if (!emit_q || !job_full) begin
						wp_q    <= wp_next;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: src/stled_div.sv
`timescale 1ns / 1ps
module stled_div import stled_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [SUM_W-1:0] num,
	input  logic [POW_W-1:0] den,
	output logic             done,
	output logic [SUM_W-1:0] quot
);

	localparam int CNT_W = $clog2(SUM_W);

	logic [SUM_W-1:0] num_q;
	logic [POW_W-1:0] rem_q;
	logic [POW_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;
	logic [POW_W:0]   rem_sh;
	logic             ge;

	assign rem_sh = {rem_q, num_q[SUM_W-1]};
	assign ge     = (rem_sh >= {1'b0, den_q});
	assign done   = done_q;
	assign quot   = num_q;

	// restoring division, one quotient bit a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q  <= '0;
			rem_q  <= '0;
			den_q  <= '0;
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				num_q <= num;
				den_q <= den;
				rem_q <= '0;
				cnt_q <= '0;
				run_q <= 1'b1;
			end else if (run_q) begin
				rem_q <= ge ? POW_W'(rem_sh - {1'b0, den_q}) : rem_sh[POW_W-1:0];
				num_q <= {num_q[SUM_W-2:0], ge};
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(SUM_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// File: src/stled_back.sv
`timescale 1ns / 1ps
module stled_back import stled_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  job_t               job,
	input  logic               job_empty,
	output logic               job_pop,
	input  logic [THR_W-1:0]   threshold,
	output logic               empty,
	input  logic               pop,
	output logic [POW_W-1:0]   short_power,
	output logic [POW_W-1:0]   long_power,
	output logic [RATIO_W-1:0] power_ratio,
	output logic               event_detected,
	output logic [IDX_W-1:0]   sample_index
);

	typedef enum logic [2:0] {
		B_IDLE, B_DSHORT, B_DLONG, B_DRATIO, B_OUT
	} state_t;

	state_t             state_q;
	job_t               job_q;
	logic [POW_W-1:0]   sp_q;
	logic [POW_W-1:0]   lp_q;
	logic [RATIO_W-1:0] ratio_q;
	logic               ovalid_q;
	logic [POW_W-1:0]   osp_q;
	logic [POW_W-1:0]   olp_q;
	logic [RATIO_W-1:0] oratio_q;
	logic               oevent_q;
	logic [IDX_W-1:0]   oidx_q;

	logic               div_start;
	logic [SUM_W-1:0]   div_num;
	logic [POW_W-1:0]   div_den;
	logic               div_done;
	logic [SUM_W-1:0]   div_quot;
	logic               slot_free;

	stled_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	assign job_pop        = (state_q == B_IDLE) && !job_empty;
	assign slot_free      = !ovalid_q || pop;
	assign empty          = !ovalid_q;
	assign short_power    = osp_q;
	assign long_power     = olp_q;
	assign power_ratio    = oratio_q;
	assign event_detected = oevent_q;
	assign sample_index   = oidx_q;

	// divider operand selection
	always_comb begin
		div_start = 1'b0;
		div_num   = job.short_sum;
		div_den   = POW_W'(job.short_len);
		unique case (state_q)
			B_IDLE: div_start = !job_empty;
			B_DSHORT: begin
				div_start = div_done;
				div_num   = job_q.long_sum;
				div_den   = POW_W'(job_q.long_len);
			end
			B_DLONG: begin
				div_start = div_done && (div_quot != '0);
				div_num   = {2'b00, sp_q, 8'h00};
				div_den   = div_quot[POW_W-1:0];
			end
			default: ;
		endcase
	end

	// sequencer and result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_IDLE;
			job_q    <= '0;
			sp_q     <= '0;
			lp_q     <= '0;
			ratio_q  <= '0;
			ovalid_q <= 1'b0;
			osp_q    <= '0;
			olp_q    <= '0;
			oratio_q <= '0;
			oevent_q <= 1'b0;
			oidx_q   <= '0;
		end else begin
			if (pop && ovalid_q) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					if (!job_empty) begin
						job_q   <= job;
						state_q <= B_DSHORT;
					end
				end
				B_DSHORT: begin
					if (div_done) begin
						sp_q    <= div_quot[POW_W-1:0];
						state_q <= B_DLONG;
					end
				end
				B_DLONG: begin
					if (div_done) begin
						lp_q <= div_quot[POW_W-1:0];
						if (div_quot == '0) begin
							// no long power: full scale or zero
							ratio_q <= (sp_q != '0) ? RATIO_MAX : '0;
							state_q <= B_OUT;
						end else begin
							state_q <= B_DRATIO;
						end
					end
				end
				B_DRATIO: begin
					if (div_done) begin
						ratio_q <= (div_quot > SUM_W'(RATIO_MAX)) ? RATIO_MAX
							: div_quot[RATIO_W-1:0];
						state_q <= B_OUT;
					end
				end
				B_OUT: begin
					if (slot_free) begin
						ovalid_q <= 1'b1;
						osp_q    <= sp_q;
						olp_q    <= lp_q;
						oratio_q <= ratio_q;
						oevent_q <= (ratio_q > threshold);
						oidx_q   <= job_q.index;
						state_q  <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

endmodule

// File: src/sta_lta_event_detector.sv
`timescale 1ns / 1ps
// channel   | direction | handshake        | word
// ----------+-----------+------------------+-----------------------------------------------
// sample    | in        | push / full      | sample
// result    | out       | empty / pop      | short_power long_power power_ratio
//           |           |                  | event_detected sample_index
// config    | in        | cfg_we           | cfg_index cfg_data
//
// after reset the sample ring is cleared, with full high
// front: sliding update per sample, or a full recompute over max(short, long window) samples after a window change
// back: two or three 41-step serial divisions per result word
// sustained rate is set by the shared divider; a two-word queue lets the front run ahead
// samples before start_index give no word and do not occupy the back end
module sta_lta_event_detector import stled_pkg::*; #(
	parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          cfg_we,
	input  logic        [CFG_IDX_W-1:0]   cfg_index,
	input  logic        [CFG_W-1:0]       cfg_data,
	output logic                          empty,
	input  logic                          pop,
	output logic        [POW_W-1:0]       short_power,
	output logic        [POW_W-1:0]       long_power,
	output logic        [RATIO_W-1:0]     power_ratio,
	output logic                          event_detected,
	output logic        [IDX_W-1:0]       sample_index
);

	logic [WIN_W-1:0] short_win_q;
	logic [WIN_W-1:0] long_win_q;
	logic [THR_W-1:0] thr_q;
	logic [IDX_W-1:0] start_q;
	logic             win_changed;
	logic             f_push;
	job_t             f_job;
	logic             q_full;
	job_t             q_job;
	logic             q_empty;
	logic             b_pop;

	assign win_changed = cfg_we && (cfg_reg_t'(cfg_index) == REG_SHORT_WIN ||
		cfg_reg_t'(cfg_index) == REG_LONG_WIN);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_win_q <= RST_SHORT_WIN;
			long_win_q  <= RST_LONG_WIN;
			thr_q       <= RST_THRESHOLD;
			start_q     <= RST_START;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_SHORT_WIN:   short_win_q <= cfg_data[WIN_W-1:0];
				REG_LONG_WIN:    long_win_q  <= cfg_data[WIN_W-1:0];
				REG_THRESHOLD:   thr_q       <= cfg_data[THR_W-1:0];
				REG_START_INDEX: start_q     <= cfg_data[IDX_W-1:0];
				default: ;
			endcase
		end
	end

	stled_front #(.MAX_WINDOW(MAX_WINDOW)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.sample       (sample),
		.short_window (short_win_q),
		.long_window  (long_win_q),
		.start_index  (start_q),
		.win_changed  (win_changed),
		.job_push     (f_push),
		.job          (f_job),
		.job_full     (q_full)
	);

	stled_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_push),
		.wdata  (f_job),
		.full   (q_full),
		.pop    (b_pop),
		.rdata  (q_job),
		.empty  (q_empty)
	);

	stled_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.job            (q_job),
		.job_empty      (q_empty),
		.job_pop        (b_pop),
		.threshold      (thr_q),
		.empty          (empty),
		.pop            (pop),
		.short_power    (short_power),
		.long_power     (long_power),
		.power_ratio    (power_ratio),
		.event_detected (event_detected),
		.sample_index   (sample_index)
	);

`ifndef SYNTHESIS
	// the front never hands a word to a full queue
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		!(f_push && q_full))
		else $error("queue overrun");

	// event flag agrees with the ratio and threshold
	a_event: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (event_detected == (power_ratio > thr_q)))
		else $error("event flag mismatch");

	// no long power gives only the two fixed ratios
	a_zero_long: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && long_power == '0) |-> (power_ratio == RATIO_MAX || power_ratio == '0))
		else $error("ratio with zero long power");
`endif

endmodule
